/* hdl/ppu_pkg.sv */
// ---------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and fixed-point helpers for the particle pool
// update unit.
// ---------------------------------------------------------------------------
package ppu_pkg;

  localparam int unsigned POOL_SIZE_DEF = 32;
  localparam int unsigned SLOT_W        = 6;

  // request kinds
  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // fixed-point constants
  localparam int unsigned ONE_Q16   = 65536;
  localparam int unsigned VEL_Q16   = 6554;    // 0.1 in q0.16
  localparam int unsigned VEL_RND   = 32768;
  localparam int unsigned GRAY_HALF = 32768;
  localparam int unsigned GRAY_MUL  = 655;     // integer part of 65536/100
  localparam int unsigned GRAY_FRAC = 36;      // fractional part, hundredths
  localparam int unsigned GRAY_RND  = 50;
  localparam int unsigned GRAY_RCP  = 1311;    // 2^17/100, rounded up
  localparam int unsigned JIT_MID   = 50;
  localparam int unsigned JIT_MUL   = 6553;    // integer part of 65536/10
  localparam int unsigned JIT_FRAC  = 6;       // fractional part, tenths
  localparam int unsigned JIT_RND   = 5;
  localparam int unsigned JIT_RCP   = 205;     // 2^11/10, rounded up
  localparam int unsigned ALPHA_MUL = 5;

  typedef struct packed {
    logic [16:0]        life;
    logic signed [18:0] alpha;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        gray;
  } slot_rec_t;

  typedef struct packed {
    logic              cap;
    logic              rd_en;
    logic              calc_go;
    logic              spawn_wr;
    logic [SLOT_W-1:0] rd_idx;
    logic [SLOT_W-1:0] probe_idx;
    logic [SLOT_W-1:0] spawn_slot;
  } ppu_cmd_t;

  typedef struct packed {
    logic              out_free;
    logic              probe_alive;
    logic [SLOT_W-1:0] hint;
  } ppu_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33] == v[32]) && (v[32] == v[31])) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = {1'b1, 31'b0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [18:0] sat_alpha(input logic signed [19:0] v);
    logic signed [18:0] r;
    if (v[19] == v[18]) begin
      r = v[18:0];
    end else if (v[19]) begin
      r = {1'b1, 18'b0};
    end else begin
      r = {1'b0, {18{1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hdl/ppu_ctrl.sv */
// ---------------------------------------------------------------------------
// ppu_ctrl
// Sequencer for the particle pool: free-slot scan for spawns and the
// read/update/emit sweep over every slot for ticks.
// ---------------------------------------------------------------------------
module ppu_ctrl #(
  parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              kind,
  output logic              in_ready,
  output ppu_pkg::ppu_cmd_t cmd,
  input  ppu_pkg::ppu_sts_t sts
);

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SPAWN_WR,
    ST_TICK
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] scan_cnt;
  logic [IDX_W-1:0] slot_sel;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_more;
  logic             calc_vld;

  logic             adv;

  always_comb begin
    adv            = !calc_vld || sts.out_free;
    in_ready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.cap        = (state == ST_IDLE) && in_valid;
    cmd.rd_en      = (state == ST_TICK) && rd_more && adv;
    cmd.calc_go    = (state == ST_TICK) && calc_vld && sts.out_free;
    cmd.spawn_wr   = (state == ST_SPAWN_WR) && sts.out_free;
    cmd.rd_idx     = ppu_pkg::SLOT_W'(rd_idx);
    cmd.probe_idx  = ppu_pkg::SLOT_W'(scan_idx);
    cmd.spawn_slot = ppu_pkg::SLOT_W'(slot_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      scan_cnt <= '0;
      slot_sel <= '0;
      rd_idx   <= '0;
      rd_more  <= 1'b0;
      calc_vld <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (kind == ppu_pkg::KIND_SPAWN) begin
              scan_idx <= sts.hint[IDX_W-1:0];
              scan_cnt <= '0;
              state    <= ST_SCAN;
            end else begin
              rd_idx   <= '0;
              rd_more  <= 1'b1;
              calc_vld <= 1'b0;
              state    <= ST_TICK;
            end
          end
        end
        ST_SCAN: begin
          if (!sts.probe_alive) begin
            slot_sel <= scan_idx;
            state    <= ST_SPAWN_WR;
          end else if (scan_cnt == LAST_IDX) begin
            // pool full: fall back to slot 0
            slot_sel <= '0;
            state    <= ST_SPAWN_WR;
          end else begin
            scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        ST_SPAWN_WR: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (cmd.rd_en) begin
            rd_idx <= rd_idx + 1'b1;
            if (rd_idx == LAST_IDX) begin
              rd_more <= 1'b0;
            end
          end
          calc_vld <= cmd.rd_en || (calc_vld && !cmd.calc_go);
          if (cmd.calc_go && !rd_more) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!calc_vld && !rd_more))
    else $error("sweep state left over in idle");

  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_TICK) && !rd_more) |-> calc_vld)
    else $error("last slot lost from update stage");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= LAST_IDX))
    else $error("free-slot scan ran past the pool");

  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (kind == ppu_pkg::KIND_TICK))
      |=> ((state == ST_TICK) && rd_more && !calc_vld && (rd_idx == '0)))
    else $error("tick sweep did not start at slot 0");
`endif

endmodule

/* hdl/ppu_datapath.sv */
// ---------------------------------------------------------------------------
// ppu_datapath
// Slot memory, live/written flags, spawn and tick arithmetic and the
// result register.
// ---------------------------------------------------------------------------
module ppu_datapath #(
  parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ppu_pkg::ppu_cmd_t  cmd,
  output ppu_pkg::ppu_sts_t  sts,
  input  logic [15:0]        dt,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] off_x,
  input  logic signed [31:0] off_y,
  input  logic signed [31:0] off_z,
  input  logic [6:0]         jitter,
  input  logic [6:0]         shade,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         slot,
  output logic               alive,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [16:0]        gray,
  output logic signed [18:0] alpha,
  output logic               last
);

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

  // captured request
  logic [15:0]        dt_r;
  logic [12:0]        mv_r;
  logic [17:0]        da_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [31:0] off_x_r, off_y_r, off_z_r;
  logic [6:0]         jitter_r, shade_r;
  logic signed [19:0] jit_r;
  logic [16:0]        gray_r;

  // slot storage
  ppu_pkg::slot_rec_t mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] alive_v;
  logic [POOL_SIZE-1:0] written_v;
  logic [IDX_W-1:0]     hint;

  // read stage
  ppu_pkg::slot_rec_t rec_q;
  logic               rd_alive_q;
  logic               rd_written_q;
  logic [IDX_W-1:0]   rd_slot_q;

  logic [28:0] mv_prod;
  logic [18:0] da_sum;

  logic signed [7:0]  jd;
  logic [6:0]         ja;
  logic [19:0]        jprod;
  logic [8:0]         jx;
  logic [16:0]        jx_prod;
  logic [18:0]        jmag;
  logic [16:0]        gprod;
  logic [12:0]        gy;
  logic [22:0]        gy_prod;

  ppu_pkg::slot_rec_t cur;
  logic [16:0]        life_cur;
  logic signed [17:0] life_diff;
  logic               live;
  logic signed [31:0] nx, ny, nz;
  logic signed [18:0] na;
  logic signed [31:0] sx, sy, sz;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  ppu_pkg::slot_rec_t wdata;
  logic               out_free;
  logic [IDX_W-1:0]   spawn_idx;

  // tick step sizes, taken from the request port
  always_comb begin
    mv_prod = 29'(dt) * 29'(ppu_pkg::VEL_Q16) + 29'(ppu_pkg::VEL_RND);
    da_sum  = 19'(dt) * 19'(ppu_pkg::ALPHA_MUL) + 19'd1;
  end

  // jitter: round((jitter-50)*6553.6), symmetric about zero
  always_comb begin
    jd      = $signed({1'b0, jitter_r}) - 8'(ppu_pkg::JIT_MID);
    ja      = jd[7] ? 7'(-jd) : jd[6:0];
    jprod   = 20'(ja) * 20'(ppu_pkg::JIT_MUL);
    jx      = 9'(ja) * 9'(ppu_pkg::JIT_FRAC) + 9'(ppu_pkg::JIT_RND);
    jx_prod = 17'(jx) * 17'(ppu_pkg::JIT_RCP);
    jmag    = 19'(jprod) + 19'(jx_prod[16:11]);
  end

  // gray: 0.5 + shade/100, rounded to nearest
  always_comb begin
    gprod   = 17'(shade_r) * 17'(ppu_pkg::GRAY_MUL);
    gy      = 13'(shade_r) * 13'(ppu_pkg::GRAY_FRAC) + 13'(ppu_pkg::GRAY_RND);
    gy_prod = 23'(gy) * 23'(ppu_pkg::GRAY_RCP);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      dt_r     <= dt;
      mv_r     <= mv_prod[28:16];
      da_r     <= da_sum[18:1];
      pos_x_r  <= pos_x;
      pos_y_r  <= pos_y;
      pos_z_r  <= pos_z;
      off_x_r  <= off_x;
      off_y_r  <= off_y;
      off_z_r  <= off_z;
      jitter_r <= jitter;
      shade_r  <= shade;
    end
    jit_r  <= jd[7] ? -$signed({1'b0, jmag}) : $signed({1'b0, jmag});
    gray_r <= 17'(ppu_pkg::GRAY_HALF) + gprod + 17'(gy_prod[22:17]);
  end

  // tick update of the slot held in the read stage
  always_comb begin
    cur       = rd_written_q ? rec_q : '0;
    life_cur  = rd_alive_q ? cur.life : '0;
    life_diff = $signed({1'b0, life_cur}) - $signed({2'b0, dt_r});
    live      = !life_diff[17] && (life_diff != '0);
    nx        = ppu_pkg::sat32(34'(cur.px) - $signed({21'b0, mv_r}));
    ny        = ppu_pkg::sat32(34'(cur.py) - $signed({21'b0, mv_r}));
    nz        = ppu_pkg::sat32(34'(cur.pz) - $signed({21'b0, mv_r}));
    na        = ppu_pkg::sat_alpha(20'(cur.alpha) - $signed({2'b0, da_r}));
  end

  // spawn placement
  always_comb begin
    sx = ppu_pkg::sat32(34'(pos_x_r) + 34'(jit_r) + 34'(off_x_r));
    sy = ppu_pkg::sat32(34'(pos_y_r) + 34'(jit_r) + 34'(off_y_r));
    sz = ppu_pkg::sat32(34'(pos_z_r) + 34'(jit_r) + 34'(off_z_r));
  end

  always_comb begin
    spawn_idx = cmd.spawn_slot[IDX_W-1:0];
    we        = cmd.spawn_wr || (cmd.calc_go && live);
    waddr     = cmd.spawn_wr ? spawn_idx : rd_slot_q;
    if (cmd.spawn_wr) begin
      wdata.life  = 17'(ppu_pkg::ONE_Q16);
      wdata.alpha = 19'(ppu_pkg::ONE_Q16);
      wdata.px    = sx;
      wdata.py    = sy;
      wdata.pz    = sz;
      wdata.gray  = gray_r;
    end else begin
      wdata.life  = life_diff[16:0];
      wdata.alpha = na;
      wdata.px    = nx;
      wdata.py    = ny;
      wdata.pz    = nz;
      wdata.gray  = cur.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rec_q <= mem[cmd.rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_alive_q   <= alive_v[cmd.rd_idx[IDX_W-1:0]];
      rd_written_q <= written_v[cmd.rd_idx[IDX_W-1:0]];
      rd_slot_q    <= cmd.rd_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive_v   <= '0;
      written_v <= '0;
      hint      <= '0;
    end else if (cmd.spawn_wr) begin
      alive_v[spawn_idx]   <= 1'b1;
      written_v[spawn_idx] <= 1'b1;
      hint                 <= spawn_idx;
    end else if (cmd.calc_go) begin
      alive_v[rd_slot_q] <= live;
    end
  end

  // result register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.spawn_wr || cmd.calc_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spawn_wr) begin
      slot  <= cmd.spawn_slot;
      alive <= 1'b1;
      out_x <= sx;
      out_y <= sy;
      out_z <= sz;
      gray  <= gray_r;
      alpha <= 19'(ppu_pkg::ONE_Q16);
      last  <= 1'b1;
    end else if (cmd.calc_go) begin
      slot  <= ppu_pkg::SLOT_W'(rd_slot_q);
      alive <= live;
      out_x <= live ? nx : cur.px;
      out_y <= live ? ny : cur.py;
      out_z <= live ? nz : cur.pz;
      gray  <= cur.gray;
      alpha <= live ? na : cur.alpha;
      last  <= (rd_slot_q == LAST_IDX);
    end
  end

  always_comb begin
    sts.out_free    = out_free;
    sts.probe_alive = alive_v[cmd.probe_idx[IDX_W-1:0]];
    sts.hint        = ppu_pkg::SLOT_W'(hint);
  end

endmodule

/* hdl/particle_pool_update_unit.sv */
// ---------------------------------------------------------------------------
// particle_pool_update_unit
// Fixed-point particle pool: spawns particles into free slots, or slot 0
// when full; advances every slot by one time step, reporting slot contents.
// ---------------------------------------------------------------------------
//   channel   handshake             payload
//   request   in_valid / in_ready   kind dt pos_x/y/z off_x/y/z jitter shade
//   result    out_valid / out_ready slot alive out_x/y/z gray alpha last
//
// spawn: the free-slot scan probes k slots (1..POOL_SIZE),
//   one slot per cycle against the live-flag vector.
// tick: one slot per cycle unless a result stalls, through the slot memory's
//   single read port and single write port, then one result per slot.
// after reset the pool is empty at once; no clearing pass is needed.
// a stalled result holds the sweep; a new request is taken while the last
//   result still waits in the output register.
// ---------------------------------------------------------------------------
module particle_pool_update_unit #(
  parameter int unsigned POOL_SIZE = ppu_pkg::POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [15:0]        dt,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] off_x,
  input  logic signed [31:0] off_y,
  input  logic signed [31:0] off_z,
  input  logic [6:0]         jitter,
  input  logic [6:0]         shade,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         slot,
  output logic               alive,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [16:0]        gray,
  output logic signed [18:0] alpha,
  output logic               last
);

  ppu_pkg::ppu_cmd_t cmd;
  ppu_pkg::ppu_sts_t sts;

  ppu_ctrl #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ppu_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .dt        (dt),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .off_x     (off_x),
    .off_y     (off_y),
    .off_z     (off_z),
    .jitter    (jitter),
    .shade     (shade),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot      (slot),
    .alive     (alive),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .gray      (gray),
    .alpha     (alpha),
    .last      (last)
  );

endmodule
